// ===== hw/rtl/mxpt_pkg.sv =====
// Shared types and constants of the maximum-XOR trie block.
package mxpt_pkg;

  localparam int KEY_BITS   = 16;
  localparam int NODE_COUNT = 4096;
  localparam int NodeW      = $clog2(NODE_COUNT);
  localparam int CntW       = $clog2(NODE_COUNT + 1);
  localparam int LvlW       = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;

  typedef struct packed {
    logic [15:0] key;
    logic        restart;
  } in_req_t;

  typedef struct packed {
    logic [15:0] best_xor;
    logic        has_partner;
    logic [15:0] running_max;
    logic        store_full;
  } out_req_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_QUERY,
    ST_INSERT,
    ST_DONE
  } walk_state_e;

  typedef struct packed {
    logic                start;
    logic [KEY_BITS-1:0] key;
    logic                restart;
    logic                take;
  } walk_cmd_t;

  typedef struct packed {
    logic     busy;
    logic     done;
    out_req_t res;
  } walk_rsp_t;

endpackage

// ===== hw/rtl/mxpt_walk.sv =====
// Trie walker: node memory, root links, query and insert sequencer.
module mxpt_walk (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mxpt_pkg::walk_cmd_t cmd_i,
  output mxpt_pkg::walk_rsp_t rsp_o
);

  logic [2*mxpt_pkg::NodeW-1:0] mem [mxpt_pkg::NODE_COUNT];
  logic [2*mxpt_pkg::NodeW-1:0] rdata_q;

  mxpt_pkg::walk_state_e state_q, state_d;

  logic [mxpt_pkg::LvlW-1:0]     lvl_q, lvl_d;
  logic [mxpt_pkg::NodeW-1:0]    node_q, node_d;
  logic                          fresh_q, fresh_d;
  logic [mxpt_pkg::KEY_BITS-1:0] key_q, key_d;
  logic [mxpt_pkg::KEY_BITS-1:0] best_q, best_d;
  logic                          found_q, found_d;
  logic                          full_q, full_d;
  logic [15:0]                   max_q, max_d;
  logic [mxpt_pkg::CntW-1:0]     free_q, free_d;
  logic [mxpt_pkg::NodeW-1:0]    root0_q, root0_d, root1_q, root1_d;

  logic [mxpt_pkg::NodeW-1:0]    ch0, ch1, cw, cb, newn;
  logic                          kbit, last, q_end, i_end, store_out;
  logic [mxpt_pkg::KEY_BITS-1:0] best_new;
  logic                          we;
  logic [mxpt_pkg::NodeW-1:0]    rd_addr, wr_addr;
  logic [2*mxpt_pkg::NodeW-1:0]  wr_data;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rdata_q <= mem[rd_addr];
  end

  always_comb begin
    if (node_q == '0) begin
      ch0 = root0_q;
      ch1 = root1_q;
    end else if (state_q == mxpt_pkg::ST_INSERT && fresh_q) begin
      ch0 = '0;
      ch1 = '0;
    end else begin
      ch0 = rdata_q[mxpt_pkg::NodeW-1:0];
      ch1 = rdata_q[2*mxpt_pkg::NodeW-1:mxpt_pkg::NodeW];
    end
    kbit      = key_q[lvl_q];
    cw        = kbit ? ch0 : ch1;
    cb        = kbit ? ch1 : ch0;
    last      = (lvl_q == '0);
    newn      = free_q[mxpt_pkg::NodeW-1:0];
    store_out = (free_q >= mxpt_pkg::CntW'(mxpt_pkg::NODE_COUNT));
    q_end     = last || (cw == '0 && cb == '0);
    i_end     = last || (cb == '0 && store_out);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mxpt_pkg::ST_IDLE: begin
        if (cmd_i.start) begin
          state_d = mxpt_pkg::ST_QUERY;
        end
      end
      mxpt_pkg::ST_QUERY: begin
        if (q_end) begin
          state_d = mxpt_pkg::ST_INSERT;
        end
      end
      mxpt_pkg::ST_INSERT: begin
        if (i_end) begin
          state_d = mxpt_pkg::ST_DONE;
        end
      end
      mxpt_pkg::ST_DONE: begin
        if (cmd_i.take) begin
          state_d = mxpt_pkg::ST_IDLE;
        end
      end
      default: state_d = mxpt_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    lvl_d    = lvl_q;
    node_d   = node_q;
    fresh_d  = fresh_q;
    key_d    = key_q;
    best_d   = best_q;
    found_d  = found_q;
    full_d   = full_q;
    max_d    = max_q;
    free_d   = free_q;
    root0_d  = root0_q;
    root1_d  = root1_q;
    we       = 1'b0;
    rd_addr  = node_q;
    wr_addr  = node_q;
    wr_data  = '0;
    best_new = best_q;
    unique case (state_q)
      mxpt_pkg::ST_IDLE: begin
        if (cmd_i.start) begin
          key_d   = cmd_i.key;
          node_d  = '0;
          lvl_d   = mxpt_pkg::LvlW'(mxpt_pkg::KEY_BITS - 1);
          best_d  = '0;
          found_d = 1'b1;
          full_d  = 1'b0;
          fresh_d = 1'b0;
          if (cmd_i.restart) begin
            root0_d = '0;
            root1_d = '0;
            free_d  = mxpt_pkg::CntW'(1);
            max_d   = '0;
          end
        end
      end
      mxpt_pkg::ST_QUERY: begin
        if (cw != '0) begin
          node_d          = cw;
          best_new[lvl_q] = 1'b1;
        end else begin
          node_d = cb;
        end
        rd_addr = node_d;
        best_d  = best_new;
        if (cw == '0 && cb == '0) begin
          found_d = 1'b0;
          best_d  = '0;
        end else if (last && 16'(best_new) > max_q) begin
          max_d = 16'(best_new);
        end
        if (q_end) begin
          node_d  = '0;
          lvl_d   = mxpt_pkg::LvlW'(mxpt_pkg::KEY_BITS - 1);
          fresh_d = 1'b0;
        end else begin
          lvl_d = lvl_q - 1'b1;
        end
      end
      mxpt_pkg::ST_INSERT: begin
        if (cb != '0) begin
          node_d  = cb;
          fresh_d = 1'b0;
          rd_addr = cb;
        end else if (store_out) begin
          full_d = 1'b1;
          if (fresh_q) begin
            we = 1'b1;
          end
        end else begin
          free_d  = free_q + 1'b1;
          node_d  = newn;
          fresh_d = 1'b1;
          if (node_q == '0) begin
            if (kbit) begin
              root1_d = newn;
            end else begin
              root0_d = newn;
            end
          end else begin
            we      = 1'b1;
            wr_data = kbit ? {newn, ch0} : {ch1, newn};
          end
        end
        if (!i_end) begin
          lvl_d = lvl_q - 1'b1;
        end
      end
      mxpt_pkg::ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mxpt_pkg::ST_IDLE;
      free_q  <= mxpt_pkg::CntW'(1);
      max_q   <= '0;
      root0_q <= '0;
      root1_q <= '0;
    end else begin
      state_q <= state_d;
      free_q  <= free_d;
      max_q   <= max_d;
      root0_q <= root0_d;
      root1_q <= root1_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lvl_q   <= lvl_d;
    node_q  <= node_d;
    fresh_q <= fresh_d;
    key_q   <= key_d;
    best_q  <= best_d;
    found_q <= found_d;
    full_q  <= full_d;
  end

  always_comb begin
    rsp_o.busy            = (state_q != mxpt_pkg::ST_IDLE);
    rsp_o.done            = (state_q == mxpt_pkg::ST_DONE);
    rsp_o.res.best_xor    = 16'(best_q);
    rsp_o.res.has_partner = found_q;
    rsp_o.res.running_max = max_q;
    rsp_o.res.store_full  = full_q;
  end

endmodule

// ===== hw/rtl/max_xor_pair_trie.sv =====
// Top level of the maximum-XOR trie block: request handshake and result register.
//
// Input channel: in_valid_i / in_stall_o carry one request (key, restart).
// A request is taken at a rising edge with in_valid_i high and in_stall_o
// low. Output channel: out_valid_o / out_stall_i carry one result per
// request (best_xor, has_partner, running_max, store_full).
// Each request is accepted, walked through the trie by a query walk of up
// to KEY_BITS levels and an insert walk of up to KEY_BITS levels, and its
// result is handed over; the query walk stops early at a dead end and the
// insert walk stops early when the node store runs out. Each walk step is
// one dependent read of the node memory.
// One request is worked on at a time; in_stall_o is high while it runs.
// A finished result waits in the output register, and the next request is
// accepted meanwhile; a second result waits inside until that one is taken.
// Reset empties the trie and clears the running maximum; the node memory
// itself is not cleared, since the links of an allocated node are written before they are ever read.
// restart empties the trie the same way before its key is handled.
module max_xor_pair_trie (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  mxpt_pkg::in_req_t  in_req_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output mxpt_pkg::out_req_t out_req_o
);

  mxpt_pkg::walk_cmd_t cmd;
  mxpt_pkg::walk_rsp_t rsp;
  logic                out_valid_q, out_valid_d;
  mxpt_pkg::out_req_t  out_q, out_d;
  logic                out_free;

  assign in_stall_o  = rsp.busy;
  assign out_free    = !out_valid_q || !out_stall_i;

  always_comb begin
    cmd.start   = in_valid_i && !rsp.busy;
    cmd.key     = in_req_i.key[mxpt_pkg::KEY_BITS-1:0];
    cmd.restart = in_req_i.restart;
    cmd.take    = rsp.done && out_free;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd.take) begin
      out_valid_d = 1'b1;
      out_d       = rsp.res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

  mxpt_walk u_walk (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .rsp_o  (rsp)
  );

endmodule

// ===== tb/tb_max_xor_pair_trie.sv =====
// Self-checking testbench of the maximum-XOR trie block, with its own trie predictor.
module tb_max_xor_pair_trie;

  localparam int CycleLimit = 1_000_000;
  localparam int TotalReqs  = 1650;
  localparam int DrainWait  = 100;

  logic               clk_i;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_stall_o;
  mxpt_pkg::in_req_t  in_req_i    = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  mxpt_pkg::out_req_t out_req_o;

  max_xor_pair_trie uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_req_o   (out_req_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // trie predictor state
  bit [mxpt_pkg::NodeW-1:0] zero_link [mxpt_pkg::NODE_COUNT];
  bit [mxpt_pkg::NodeW-1:0] one_link  [mxpt_pkg::NODE_COUNT];
  bit [mxpt_pkg::CntW-1:0]  free_node = mxpt_pkg::CntW'(1);
  bit [15:0]                peak_xor  = '0;

  // node usage tracker for shaping stimulus
  bit prefix_seen [int];
  int nodes_used = 0;

  mxpt_pkg::in_req_t  pending_reqs [$];
  mxpt_pkg::out_req_t results_due  [$];

  int  errors     = 0;
  int  n_reqs     = 0;
  int  n_sent     = 0;
  int  n_restarts = 0;
  int  n_partner  = 0;
  int  n_full     = 0;
  int  dead_ends  = 0;
  int  cycles     = 0;
  int  in_gap     = 0;
  int  stall_left = 0;
  bit  in_calm    = 1'b0;
  bit  out_calm   = 1'b0;

  function automatic int pick_gap(bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 60);
  endfunction

  function automatic mxpt_pkg::out_req_t predict_xor(mxpt_pkg::in_req_t req);
    logic [15:0]                k;
    logic [15:0]                best;
    logic [mxpt_pkg::NodeW-1:0] cur;
    logic [mxpt_pkg::NodeW-1:0] nxt;
    logic                       found;
    logic                       full;
    logic                       b;
    int                         lvl;
    mxpt_pkg::out_req_t         r;
    k = req.key;
    if (req.restart) begin
      zero_link[0] = '0;
      one_link[0]  = '0;
      free_node    = mxpt_pkg::CntW'(1);
      peak_xor     = '0;
    end
    cur   = '0;
    best  = '0;
    found = 1'b1;
    for (lvl = mxpt_pkg::KEY_BITS - 1; lvl >= 0; lvl--) begin
      b   = k[lvl];
      nxt = b ? zero_link[cur] : one_link[cur];
      if (nxt != 0) begin
        cur       = nxt;
        best[lvl] = 1'b1;
      end else begin
        nxt = b ? one_link[cur] : zero_link[cur];
        if (nxt == 0) begin
          found = 1'b0;
          if (lvl != mxpt_pkg::KEY_BITS - 1) dead_ends++;
          break;
        end
        cur = nxt;
      end
    end
    if (!found) best = '0;
    if (found && best > peak_xor) peak_xor = best;
    cur  = '0;
    full = 1'b0;
    for (lvl = mxpt_pkg::KEY_BITS - 1; lvl >= 0; lvl--) begin
      b   = k[lvl];
      nxt = b ? one_link[cur] : zero_link[cur];
      if (nxt == 0) begin
        if (free_node >= mxpt_pkg::NODE_COUNT) begin
          full = 1'b1;
          break;
        end
        nxt = free_node[mxpt_pkg::NodeW-1:0];
        free_node++;
        zero_link[nxt] = '0;
        one_link[nxt]  = '0;
        if (b) one_link[cur] = nxt;
        else zero_link[cur] = nxt;
      end
      cur = nxt;
    end
    r.best_xor    = best;
    r.has_partner = found;
    r.running_max = peak_xor;
    r.store_full  = full;
    return r;
  endfunction

  function automatic int nodes_needed(logic [15:0] k);
    int len;
    int n;
    n = 0;
    for (len = 1; len <= mxpt_pkg::KEY_BITS; len++) begin
      if (!prefix_seen.exists((len << 16) | int'(k >> (mxpt_pkg::KEY_BITS - len)))) n++;
    end
    return n;
  endfunction

  // queue a request; report whether its insert runs out of nodes
  function automatic bit add_req(logic [15:0] k, logic rs);
    mxpt_pkg::in_req_t q;
    int                len;
    int                id;
    q.key     = k;
    q.restart = rs;
    pending_reqs.push_back(q);
    if (rs) begin
      prefix_seen.delete();
      nodes_used = 0;
    end
    for (len = 1; len <= mxpt_pkg::KEY_BITS; len++) begin
      id = (len << 16) | int'(k >> (mxpt_pkg::KEY_BITS - len));
      if (!prefix_seen.exists(id)) begin
        if (nodes_used >= mxpt_pkg::NODE_COUNT - 1) return 1'b1;
        prefix_seen[id] = 1'b1;
        nodes_used++;
      end
    end
    return 1'b0;
  endfunction

  // request driver
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || n_sent == n_reqs)) begin
      if (in_valid_i) begin
        if ($urandom_range(0, 49) == 0) in_calm = ($urandom_range(0, 2) == 0);
        in_gap = pick_gap(in_calm);
      end
      if (in_gap != 0 || pending_reqs.size() == 0) begin
        if (in_gap != 0) in_gap--;
        in_valid_i <= 1'b0;
      end else begin
        in_req_i   <= pending_reqs.pop_front();
        in_valid_i <= 1'b1;
        n_sent++;
      end
    end
  end

  // result back-pressure
  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else begin
      stall_left = pick_gap(out_calm);
      out_stall_i <= (stall_left != 0);
      if (stall_left != 0) stall_left--;
    end
  end

  // handshake monitor and result check
  always @(posedge clk_i) begin
    mxpt_pkg::out_req_t want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        results_due.push_back(predict_xor(in_req_i));
        n_reqs++;
        if (in_req_i.restart) n_restarts++;
      end
      if (out_valid_o && !out_stall_i) begin
        if ($urandom_range(0, 49) == 0) out_calm = ($urandom_range(0, 2) == 0);
        if (results_due.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("ERROR: unexpected result xor=%h partner=%b max=%h full=%b",
                     out_req_o.best_xor, out_req_o.has_partner,
                     out_req_o.running_max, out_req_o.store_full);
        end else begin
          want = results_due.pop_front();
          if (want.has_partner) n_partner++;
          if (want.store_full) n_full++;
          if (out_req_o !== want) begin
            errors++;
            if (errors <= 10)
              $display("ERROR: result %0d exp %h/%b/%h/%b got %h/%b/%h/%b",
                       n_reqs - results_due.size() - 1,
                       want.best_xor, want.has_partner, want.running_max, want.store_full,
                       out_req_o.best_xor, out_req_o.has_partner,
                       out_req_o.running_max, out_req_o.store_full);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("Timeout after %0d cycles with %0d results outstanding",
               cycles, results_due.size());
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    logic [15:0] k;
    logic [15:0] base;
    logic [15:0] mask;
    int          seg_len;
    int          fills;
    int          tail;
    int          room;
    int          tries;
    int          j;
    bit          full_seen;
    bit          rs;

    void'(add_req(16'h0000, 1'b1));
    void'(add_req(16'hFFFF, 1'b0));
    void'(add_req(16'h0000, 1'b0));
    void'(add_req(16'h8000, 1'b0));
    void'(add_req(16'h7FFF, 1'b0));
    void'(add_req(16'h5555, 1'b0));
    void'(add_req(16'hAAAA, 1'b0));
    void'(add_req(16'h0001, 1'b0));
    void'(add_req(16'h1234, 1'b1));
    void'(add_req(16'h1234, 1'b0));
    void'(add_req(16'h1235, 1'b0));
    void'(add_req(16'hFFFF, 1'b1));
    void'(add_req(16'hFFFF, 1'b0));
    void'(add_req(16'hFFFE, 1'b0));
    void'(add_req(16'h0000, 1'b0));
    void'(add_req(16'h8001, 1'b1));
    void'(add_req(16'h7FFE, 1'b0));
    void'(add_req(16'h4000, 1'b0));

    fills = 0;
    while (pending_reqs.size() < TotalReqs) begin
      if (fills < 2 && pending_reqs.size() > 300 + 650 * fills) begin
        // fill the node store, then walk into the cut-off paths
        fills++;
        full_seen = 1'b0;
        tail      = 0;
        void'(add_req(16'($urandom), 1'b1));
        while (tail < 12) begin
          k    = 16'($urandom);
          room = mxpt_pkg::NODE_COUNT - 1 - nodes_used;
          if (!full_seen && room > 0 && room < mxpt_pkg::KEY_BITS) begin
            for (tries = 0; tries < 50 && nodes_needed(k) <= room; tries++)
              k = 16'($urandom);
          end
          if (add_req(k, 1'b0)) begin
            full_seen = 1'b1;
            void'(add_req(~k, 1'b0));
          end
          if (full_seen) tail++;
        end
      end else begin
        seg_len = $urandom_range(1, 40);
        rs      = ($urandom_range(0, 3) != 0);
        base    = 16'($urandom);
        case ($urandom_range(0, 2))
          0: mask = 16'hFFFF;
          1: mask = 16'($urandom) & 16'($urandom) & 16'($urandom);
          default: mask = 16'($urandom);
        endcase
        for (j = 0; j < seg_len; j++)
          void'(add_req(base ^ (16'($urandom) & mask),
                        (rs && j == 0) || ($urandom_range(0, 49) == 0)));
      end
    end

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (pending_reqs.size() != 0 || in_valid_i || results_due.size() != 0)
      @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);

    if (results_due.size() != 0) begin
      $display("ERROR: %0d expected results never arrived", results_due.size());
      errors += results_due.size();
    end
    $display("Covered %0d requests, %0d restarts, %0d results with a partner",
             n_reqs, n_restarts, n_partner);
    $display("Store ran out on %0d inserts, %0d walks hit a dead end, %0d mismatches",
             n_full, dead_ends, errors);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/mxpt_pkg.sv
hw/rtl/mxpt_walk.sv
hw/rtl/max_xor_pair_trie.sv
tb/tb_max_xor_pair_trie.sv
